FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Self-contained; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while the reset is high.
`define ASSERT_SYNC(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

FILE: sv/rmsi_pkg.sv
// Package of the running median unit: sizes, types, status codes and states.
// Used by every module of the block; depends on nothing.
package rmsi_pkg;

   localparam int MAX_ITEMS  = 64;
   localparam int IDX_W      = $clog2(MAX_ITEMS);
   localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
   localparam int SAMPLE_W   = 7;
   localparam int MEDIAN_W   = 8;
   localparam int COUNT_OUT_W = 7;
   localparam int STATUS_W   = 2;
   localparam int GROUP_SIZE = 8;
   localparam int N_GROUPS   = (MAX_ITEMS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_ITEMS  = N_GROUPS * GROUP_SIZE;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 7'd1;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 7'd100;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [MEDIAN_W-1:0] median_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;

   // Broadcast to every cell for one insertion.
   typedef struct packed {
      logic       insert;
      sample_type sample;
      cnt_type    count;
   } cell_ctrl_type;

   // Positions of the two middle samples after the insertion.
   typedef struct packed {
      idx_type lo_idx;
      idx_type hi_idx;
   } tap_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TAP,
      ST_SUM
   } rmsi_state_type;

endpackage

FILE: sv/running_median_sorted_insert_unit.sv
// Running median unit: a sorted chain of cells with a median read-out tree.
// Depends on rmsi_pkg, rmsi_cell and rmsi_median_tree.
//
// Usage:
//   Each transfer on the req_ channel carries one sample. A sample in 1..100
//   is inserted into the sorted chain when room is left; other samples and
//   samples that meet a full chain are not stored. Each input transfer gives
//   exactly one rsp_ transfer with twice the median of the stored samples,
//   the count held after the item and a status code (0 stored, 1 out of
//   range, 2 chain full). An empty chain reports a median of 0.
//   Timing: the insertion happens in the cycle of the input transfer, the
//   middle samples are gathered by a two-level registered OR tree, and the
//   result is registered in ST_SUM once the result register is free. One
//   item is handled at a time: req_tready is high only in ST_IDLE, so a new
//   input transfer is not taken until the last item's result is written.
//   The result register lets the next input transfer be taken while a
//   result still waits; a stalled receiver holds rsp_ steady and the block
//   stops taking input once a second result is ready behind it.
//   Reset empties the chain by clearing the count and drops any result.
module running_median_sorted_insert_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] sample, [7] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] median_doubled, [14:8] stored_count,
                                    // [16:15] status, [23:17] zero
);

   rmsi_pkg::rmsi_state_type state_ff, state_in;
   rmsi_pkg::cnt_type        count_ff, count_in;
   logic [rmsi_pkg::STATUS_W-1:0] status_ff, status_in;
   rmsi_pkg::tap_sel_type    tap_sel_ff, tap_sel_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [23:0]              rsp_data_ff, rsp_data_in;

   rmsi_pkg::sample_type     sample;
   rmsi_pkg::cell_ctrl_type  ctrl;
   logic                     accept;
   logic                     in_range;
   logic                     full;
   rmsi_pkg::median_type     median_sum;
   rmsi_pkg::median_type     median;

   rmsi_pkg::sample_type     values  [rmsi_pkg::MAX_ITEMS];
   rmsi_pkg::sample_type     lefts   [rmsi_pkg::MAX_ITEMS];
   rmsi_pkg::sample_type     lo_taps [rmsi_pkg::MAX_ITEMS];
   rmsi_pkg::sample_type     hi_taps [rmsi_pkg::MAX_ITEMS];

   assign sample     = req_tdata[rmsi_pkg::SAMPLE_W-1:0];
   assign req_tready = (state_ff == rmsi_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_range   = (sample >= rmsi_pkg::SAMPLE_MIN) && (sample <= rmsi_pkg::SAMPLE_MAX);
   assign full       = (count_ff == rmsi_pkg::CNT_W'(rmsi_pkg::MAX_ITEMS));

   always_comb begin
      if (!in_range) begin
         status_in = rmsi_pkg::STATUS_RANGE;
      end else if (full) begin
         status_in = rmsi_pkg::STATUS_FULL;
      end else begin
         status_in = rmsi_pkg::STATUS_OK;
      end
   end

   assign ctrl.insert = accept && (status_in == rmsi_pkg::STATUS_OK);
   assign ctrl.sample = sample;
   assign ctrl.count  = count_ff;
   assign count_in    = count_ff + rmsi_pkg::CNT_W'(ctrl.insert);

   // The two middle positions of the count after this item.
   always_comb begin
      tap_sel_in.hi_idx = rmsi_pkg::IDX_W'(count_in >> 1);
      if (count_in == '0) begin
         tap_sel_in.lo_idx = '0;
      end else begin
         tap_sel_in.lo_idx = rmsi_pkg::IDX_W'((count_in - rmsi_pkg::CNT_W'(1)) >> 1);
      end
   end

   for (genvar i = 0; i < rmsi_pkg::MAX_ITEMS; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign lefts[i] = '0;
      end else begin : g_rest
         assign lefts[i] = values[i-1];
      end

      rmsi_cell u_cell (
         .clock      (clock),
         .cell_index (rmsi_pkg::IDX_W'(i)),
         .ctrl       (ctrl),
         .tap_sel    (tap_sel_ff),
         .left_value (lefts[i]),
         .value      (values[i]),
         .lo_tap     (lo_taps[i]),
         .hi_tap     (hi_taps[i])
      );
   end

   rmsi_median_tree u_tree (
      .clock      (clock),
      .lo_taps    (lo_taps),
      .hi_taps    (hi_taps),
      .median_sum (median_sum)
   );

   assign median = (count_ff == '0) ? '0 : median_sum;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         rmsi_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = rmsi_pkg::ST_TAP;
            end
         end
         rmsi_pkg::ST_TAP: begin
            state_in = rmsi_pkg::ST_SUM;
         end
         rmsi_pkg::ST_SUM: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, status_ff,
                               rmsi_pkg::COUNT_OUT_W'(count_ff), median};
               state_in     = rmsi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rmsi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmsi_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         status_ff  <= status_in;
         tap_sel_ff <= tap_sel_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: sv/rmsi_cell.sv
// One compare-and-shift cell of the sorted chain, holding one stored sample.
// Depends on rmsi_pkg for types.
module rmsi_cell (
   input  logic                  clock,
   input  rmsi_pkg::idx_type     cell_index,
   input  rmsi_pkg::cell_ctrl_type ctrl,
   input  rmsi_pkg::tap_sel_type tap_sel,
   input  rmsi_pkg::sample_type  left_value,
   output rmsi_pkg::sample_type  value,
   output rmsi_pkg::sample_type  lo_tap,
   output rmsi_pkg::sample_type  hi_tap
);

   rmsi_pkg::sample_type value_ff;
   rmsi_pkg::sample_type value_in;
   logic occupied;
   logic at_end;
   logic left_le;

   always_comb begin
      occupied = rmsi_pkg::CNT_W'(cell_index) < ctrl.count;
      at_end   = rmsi_pkg::CNT_W'(cell_index) == ctrl.count;
      // The first cell has no left neighbor, so the sample always fits there.
      left_le  = (cell_index == '0) || (left_value <= ctrl.sample);
      value_in = value_ff;
      // A cell takes the sample where its left neighbor is not larger,
      // otherwise it takes over the neighbor's value and the row shifts right.
      if (ctrl.insert && ((occupied && (value_ff > ctrl.sample)) || at_end)) begin
         value_in = left_le ? ctrl.sample : left_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value  = value_ff;
   assign lo_tap = (cell_index == tap_sel.lo_idx) ? value_ff : '0;
   assign hi_tap = (cell_index == tap_sel.hi_idx) ? value_ff : '0;

endmodule

FILE: sv/rmsi_median_tree.sv
// Registered OR tree that gathers the two middle samples and adds them.
// Depends on rmsi_pkg for sizes and types.
module rmsi_median_tree (
   input  logic                 clock,
   input  rmsi_pkg::sample_type lo_taps [rmsi_pkg::MAX_ITEMS],
   input  rmsi_pkg::sample_type hi_taps [rmsi_pkg::MAX_ITEMS],
   output rmsi_pkg::median_type median_sum
);

   rmsi_pkg::sample_type lo_pad [rmsi_pkg::PAD_ITEMS];
   rmsi_pkg::sample_type hi_pad [rmsi_pkg::PAD_ITEMS];
   rmsi_pkg::sample_type lo_group_ff [rmsi_pkg::N_GROUPS];
   rmsi_pkg::sample_type hi_group_ff [rmsi_pkg::N_GROUPS];
   rmsi_pkg::sample_type lo_group_in [rmsi_pkg::N_GROUPS];
   rmsi_pkg::sample_type hi_group_in [rmsi_pkg::N_GROUPS];
   rmsi_pkg::sample_type lo_all;
   rmsi_pkg::sample_type hi_all;

   for (genvar i = 0; i < rmsi_pkg::PAD_ITEMS; i++) begin : g_pad
      if (i < rmsi_pkg::MAX_ITEMS) begin : g_used
         assign lo_pad[i] = lo_taps[i];
         assign hi_pad[i] = hi_taps[i];
      end else begin : g_spare
         assign lo_pad[i] = '0;
         assign hi_pad[i] = '0;
      end
   end

   // Only the selected cell drives a non-zero tap, so an OR picks it out.
   for (genvar g = 0; g < rmsi_pkg::N_GROUPS; g++) begin : g_group
      always_comb begin
         lo_group_in[g] = '0;
         hi_group_in[g] = '0;
         for (int k = 0; k < rmsi_pkg::GROUP_SIZE; k++) begin
            lo_group_in[g] = lo_group_in[g] | lo_pad[g * rmsi_pkg::GROUP_SIZE + k];
            hi_group_in[g] = hi_group_in[g] | hi_pad[g * rmsi_pkg::GROUP_SIZE + k];
         end
      end

      always_ff @(posedge clock) begin
         lo_group_ff[g] <= lo_group_in[g];
         hi_group_ff[g] <= hi_group_in[g];
      end
   end

   always_comb begin
      lo_all = '0;
      hi_all = '0;
      for (int g = 0; g < rmsi_pkg::N_GROUPS; g++) begin
         lo_all = lo_all | lo_group_ff[g];
         hi_all = hi_all | hi_group_ff[g];
      end
   end

   assign median_sum = rmsi_pkg::MEDIAN_W'(lo_all) + rmsi_pkg::MEDIAN_W'(hi_all);

endmodule

FILE: sv/rmsi_checker.sv
// Port-level checks of the running median unit, attached by a bind.
// Depends on assert_macros.svh and the top-level port list.
`include "assert_macros.svh"

module rmsi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   logic req_fire;

   assign req_fire = req_tvalid && req_tready && (req_tdata[7] == 1'b0 || req_tdata[7] == 1'b1);

   // A stalled result keeps its payload.
   `ASSERT_SYNC(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // Reset drops any pending result.
   `ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid)

   // Twice the median of samples in 1..100 never exceeds 200.
   `ASSERT_SYNC(a_median_bound, clock, reset, rsp_tvalid |-> rsp_tdata[7:0] <= 8'd200)

   // An input transfer never yields a result in the next cycle.
   `ASSERT_SYNC(a_latency, clock, reset, req_fire && !rsp_tvalid |=> !rsp_tvalid)

endmodule

bind running_median_sorted_insert_unit rmsi_checker u_rmsi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: test/running_median_sorted_insert_unit_test.sv
// Self-checking testbench of running_median_sorted_insert_unit: a table of directed
// samples, then random samples that fill the sorted store and keep hitting it when full.
// Depends on rmsi_pkg and the unit itself; results are checked against a local predictor.
module running_median_sorted_insert_unit_test;

   localparam int TOTAL_ITEMS = 650;
   localparam int QUIET_FROM  = 560;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 12;
   localparam int DIR_N       = 20;

   typedef struct packed {
      rmsi_pkg::median_type                 median;
      logic [rmsi_pkg::COUNT_OUT_W-1:0]     count;
      logic [rmsi_pkg::STATUS_W-1:0]        status;
   } median_rsp_type;

   typedef struct packed {
      rmsi_pkg::sample_type sample;
      logic                 typed;
      median_rsp_type       rsp;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [6:0] sample, [7] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [7:0] median_doubled, [14:8] stored_count,
                                     // [16:15] status, [23:17] zero

   running_median_sorted_insert_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Directed samples. Rows marked typed carry an expectation that is obvious from
   // the rules; all other rows are checked against the predictor.
   dir_row_type dir_rows [DIR_N] = '{
      '{7'd0,   1'b1, '{8'd0,   7'd0, rmsi_pkg::STATUS_RANGE}},
      '{7'd127, 1'b1, '{8'd0,   7'd0, rmsi_pkg::STATUS_RANGE}},
      '{7'd101, 1'b1, '{8'd0,   7'd0, rmsi_pkg::STATUS_RANGE}},
      '{7'd100, 1'b1, '{8'd200, 7'd1, rmsi_pkg::STATUS_OK}},
      '{7'd100, 1'b1, '{8'd200, 7'd2, rmsi_pkg::STATUS_OK}},
      '{7'd1,   1'b0, '0},
      '{7'd1,   1'b0, '0},
      '{7'd1,   1'b0, '0},
      '{7'd1,   1'b0, '0},
      '{7'd0,   1'b0, '0},
      '{7'd127, 1'b0, '0},
      '{7'd64,  1'b0, '0},
      '{7'd85,  1'b0, '0},
      '{7'd42,  1'b0, '0},
      '{7'd100, 1'b0, '0},
      '{7'd50,  1'b0, '0},
      '{7'd51,  1'b0, '0},
      '{7'd2,   1'b0, '0},
      '{7'd99,  1'b0, '0},
      '{7'd101, 1'b0, '0}
   };

   // Predictor state: the samples held in ascending order.
   rmsi_pkg::sample_type held_samples [rmsi_pkg::MAX_ITEMS];
   int          held_count = 0;
   int          peak_count = 0;

   median_rsp_type pending_results [$];
   int          mismatch_count = 0;
   int          checked_count = 0;
   int          sent_count = 0;
   int          stored_seen = 0;
   int          range_seen = 0;
   int          full_seen = 0;
   int          cycle_count = 0;
   bit          quiet = 1'b0;
   int          stall_left = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
   endtask

   // Inserts a sample the way the unit should and returns the result it must give.
   task automatic predict_sample(input rmsi_pkg::sample_type s, output median_rsp_type r);
      int pos;
      int mid;
      int sum;
      if (s < rmsi_pkg::SAMPLE_MIN || s > rmsi_pkg::SAMPLE_MAX) begin
         r.status = rmsi_pkg::STATUS_RANGE;
         range_seen++;
      end else if (held_count >= rmsi_pkg::MAX_ITEMS) begin
         r.status = rmsi_pkg::STATUS_FULL;
         full_seen++;
      end else begin
         pos = held_count;
         // Equal samples stay ahead of the new one.
         while (pos > 0 && held_samples[pos-1] > s) begin
            held_samples[pos] = held_samples[pos-1];
            pos--;
         end
         held_samples[pos] = s;
         held_count++;
         r.status = rmsi_pkg::STATUS_OK;
         stored_seen++;
      end
      mid = held_count / 2;
      if (held_count == 0)
         sum = 0;
      else if (held_count % 2 == 1)
         sum = 2 * held_samples[mid];
      else
         sum = held_samples[mid-1] + held_samples[mid];
      r.median = sum[rmsi_pkg::MEDIAN_W-1:0];
      r.count  = held_count[rmsi_pkg::COUNT_OUT_W-1:0];
      if (held_count > peak_count)
         peak_count = held_count;
   endtask

   // Drives one sample, waits for its transfer, then maybe leaves a gap.
   task automatic send_sample(input rmsi_pkg::sample_type s, input bit typed,
                              input median_rsp_type typed_rsp);
      median_rsp_type r;
      int gap;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {1'b0, s};
      do @(posedge clock); while (!req_tready);
      predict_sample(s, r);
      pending_results.push_back(typed ? typed_rsp : r);
      sent_count++;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         @(negedge clock);
         req_tvalid = 1'b0;
         req_tdata  = $urandom_range(0, 255);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Valid samples lean on the extremes; noise is always out of range.
   function automatic rmsi_pkg::sample_type pick_sample(input int valid_pct);
      if ($urandom_range(0, 99) < valid_pct) begin
         case ($urandom_range(0, 9))
            0:       return rmsi_pkg::SAMPLE_MIN;
            1:       return rmsi_pkg::SAMPLE_MAX;
            default: return rmsi_pkg::sample_type'($urandom_range(1, 100));
         endcase
      end
      return $urandom_range(0, 1) ? rmsi_pkg::sample_type'(0)
                                  : rmsi_pkg::sample_type'($urandom_range(101, 127));
   endfunction

   // Receiver with random stall bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      median_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result transfer with nothing pending", rsp_tdata, 0);
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (rsp_tdata[7:0] !== want.median)
               report_mismatch("median_doubled", rsp_tdata[7:0], want.median);
            if (rsp_tdata[14:8] !== want.count)
               report_mismatch("stored_count", rsp_tdata[14:8], want.count);
            if (rsp_tdata[16:15] !== want.status)
               report_mismatch("status", rsp_tdata[16:15], want.status);
            if (rsp_tdata[23:17] !== 7'd0)
               report_mismatch("padding bits", rsp_tdata[23:17], 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results pending",
                  cycle_count, pending_results.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].rsp);

      // Fill the store with mostly valid samples, then keep pressing on it once full.
      while (held_count < rmsi_pkg::MAX_ITEMS)
         send_sample(pick_sample(85), 1'b0, '0);
      while (sent_count < TOTAL_ITEMS) begin
         if (sent_count >= QUIET_FROM)
            quiet = 1'b1;
         send_sample(pick_sample(50), 1'b0, '0);
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d samples sent: %0d stored, %0d out of range, %0d refused by a full store",
               sent_count, stored_seen, range_seen, full_seen);
      $display("%0d results checked, %0d mismatches, store peaked at %0d of %0d entries",
               checked_count, mismatch_count, peak_count, rmsi_pkg::MAX_ITEMS);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/rmsi_pkg.sv
sv/rmsi_cell.sv
sv/rmsi_median_tree.sv
sv/running_median_sorted_insert_unit.sv
sv/rmsi_checker.sv
test/running_median_sorted_insert_unit_test.sv
